// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_top; no dependencies.
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int PRIO_BITS  = 8;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                 kind;
    logic [VALUE_BITS-1:0] item_value;
    logic [PRIO_BITS-1:0]  item_priority;
  } in_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] head_value;
    logic [PRIO_BITS-1:0]  head_priority;
    logic [CNT_BITS-1:0]   fill_count;
    logic                  now_empty;
  } out_t;

  // One stored entry
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [PRIO_BITS-1:0]  prio;
  } entry_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_ctl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted cell row: holds an entry, compares it with the
// incoming priority and shifts toward its neighbors. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  logic      prev_lt,
  input  entry_t    prev_ent,
  input  entry_t    next_ent,
  output logic      lt,
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  assign lt  = occ && (ent_r.prio < ctl.ent.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.enq) begin
      // hold ahead of the insert point, take the new entry at it, shift behind it
      if (lt) begin
        ent_nxt = ent_r;
      end else if (prev_lt) begin
        ent_nxt = ctl.ent;
      end else begin
        ent_nxt = prev_ent;
      end
    end else if (ctl.deq) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted priority queue: a row of DEPTH cells kept in priority order.
// The result is registered and valid in the cycle after the input transaction.
// Throughput: one transaction per cycle; every cell of the row updates
// together to insert or remove an entry. A held result stalls the input through in_ready.
// Reset clears the entry count and the output valid; cell contents are not
// cleared and are only read below the count. Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_t                out_r;
  out_t                out_nxt;

  logic      acc;
  logic      is_full;
  logic      is_empty;
  cell_ctl_t ctl;

  logic   lt_c [0:DEPTH];
  entry_t ent_c [0:DEPTH-1];

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign is_full   = (count_r == FULL_CNT);
  assign is_empty  = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign lt_c[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(i);
    entry_t prev_ent;
    entry_t next_ent;

    if (i == 0) begin : g_first
      assign prev_ent = ctl.ent;
    end else begin : g_mid
      assign prev_ent = ent_c[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_ent = ent_c[i];
    end else begin : g_body
      assign next_ent = ent_c[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (IDX < count_r),
      .prev_lt  (lt_c[i]),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .lt       (lt_c[i+1]),
      .ent      (ent_c[i])
    );
  end

  always_comb begin
    ctl.enq       = 1'b0;
    ctl.deq       = 1'b0;
    ctl.ent.value = in_data.item_value;
    ctl.ent.prio  = in_data.item_priority;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (acc) begin
      out_valid_nxt         = 1'b1;
      out_nxt.status        = STAT_DONE;
      out_nxt.head_value    = '0;
      out_nxt.head_priority = '0;
      if (in_data.kind == KIND_ENQ) begin
        if (is_full) begin
          out_nxt.status = STAT_FULL;
        end else begin
          ctl.enq   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (is_empty) begin
          out_nxt.status = STAT_EMPTY;
        end else begin
          ctl.deq               = 1'b1;
          count_nxt             = count_r - 1'b1;
          out_nxt.head_value    = ent_c[0].value;
          out_nxt.head_priority = ent_c[0].prio;
        end
      end
      out_nxt.fill_count = count_nxt;
      out_nxt.now_empty  = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_enq_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.kind == KIND_ENQ && !is_full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted enqueue did not grow the count");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STAT_FULL) |-> (out_r.fill_count == FULL_CNT))
    else $error("full status with a count below depth");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.now_empty == (out_r.fill_count == '0)))
    else $error("empty flag disagrees with the count");

endmodule
